// ===== rtl/lpe_pkg.sv =====
// shared widths, register codes and status types of the pixel pulse encoder
`timescale 1ns / 1ps

package lpe_pkg;

    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned BIT_CNT_W        = 3;
    localparam int unsigned TICK_W           = 15;
    localparam int unsigned DUR_W            = 16;
    localparam int unsigned LATCH_W          = 22;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 22;
    localparam int unsigned MAX_RESET_CHUNKS = 56;
    localparam int unsigned CHUNK_CNT_W      = 6;
    localparam int unsigned DEF_MAX_CHUNK    = 65535;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH  = 2'd3;

    typedef struct packed {
        logic bit_val;
        logic last;
    } t_bit_status;

    typedef struct packed {
        logic [DUR_W-1:0] piece;
        logic             full;
        logic             last;
        logic             empty;
    } t_chunk_status;

endpackage

// ===== rtl/lpe_bit_shift.sv =====
// byte shift register, one data bit out per step, msb first
`timescale 1ns / 1ps

module lpe_bit_shift (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [lpe_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_shift,
    output lpe_pkg::t_bit_status       o_status
);

    logic [lpe_pkg::BYTE_W-1:0]    r_byte;
    logic [lpe_pkg::BIT_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_shift) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end else if (i_shift) begin
            r_byte <= {r_byte[lpe_pkg::BYTE_W-2:0], 1'b0};
        end
    end

    assign o_status.bit_val = r_byte[lpe_pkg::BYTE_W-1];
    assign o_status.last    = (r_cnt == {lpe_pkg::BIT_CNT_W{1'b1}});

endmodule

// ===== rtl/lpe_chunk_gen.sv =====
// splits the latch time into reset chunks, one chunk per step
`timescale 1ns / 1ps

module lpe_chunk_gen #(
    parameter int unsigned MAX_CHUNK = lpe_pkg::DEF_MAX_CHUNK
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [lpe_pkg::LATCH_W-1:0] i_latch,
    input  logic                        i_step,
    output lpe_pkg::t_chunk_status      o_status
);

    localparam logic [lpe_pkg::LATCH_W-1:0]     MAX_L = lpe_pkg::LATCH_W'(MAX_CHUNK);
    localparam logic [lpe_pkg::DUR_W-1:0]       MAX_D = lpe_pkg::DUR_W'(MAX_CHUNK);
    localparam logic [lpe_pkg::CHUNK_CNT_W-1:0] LAST_CNT =
        lpe_pkg::CHUNK_CNT_W'(lpe_pkg::MAX_RESET_CHUNKS - 1);

    logic [lpe_pkg::LATCH_W-1:0]     r_rem;
    logic [lpe_pkg::CHUNK_CNT_W-1:0] r_chunks;
    logic [lpe_pkg::DUR_W-1:0]       piece;
    logic [lpe_pkg::LATCH_W-1:0]     n_rem;

    assign piece = (r_rem > MAX_L) ? MAX_D : r_rem[lpe_pkg::DUR_W-1:0];
    assign n_rem = r_rem - {{(lpe_pkg::LATCH_W - lpe_pkg::DUR_W){1'b0}}, piece};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem    <= i_latch;
            r_chunks <= '0;
        end else if (i_step) begin
            r_rem    <= n_rem;
            r_chunks <= r_chunks + 1'b1;
        end
    end

    assign o_status.piece = piece;
    assign o_status.full  = (piece == MAX_D);
    // cap on chunk count drops whatever reset time is left
    assign o_status.last  = (n_rem == '0) || (r_chunks == LAST_CNT);
    assign o_status.empty = (r_rem == '0);

endmodule

// ===== rtl/led_pixel_pulse_encoder_core.sv =====
// top level: pixel byte to pulse symbol encoder with reset chunks
// the first symbol of an accepted byte enters the output register once the bit phase has begun and the slot is free
// one symbol per cycle moves through the output register while the output is not stalled, eight bit symbols per byte
// a final byte adds min(ceil(latch_ticks / MAX_CHUNK), 56) chunk symbols when latch is nonzero
// the next byte is taken in the cycle the last symbol of the current one moves out
// synchronous active-low reset clears the sequencer, output valid and all config registers
`timescale 1ns / 1ps

module led_pixel_pulse_encoder_core #(
    parameter int unsigned MAX_CHUNK = lpe_pkg::DEF_MAX_CHUNK
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input word channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpe_pkg::BYTE_W-1:0]    i_pixel_byte,
    input  logic                          i_final_byte,
    // output word channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_first_level,
    output logic [lpe_pkg::DUR_W-1:0]     o_first_duration,
    output logic                          o_second_level,
    output logic [lpe_pkg::DUR_W-1:0]     o_second_duration,
    output logic                          o_end_of_run
);

    // sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BITS  = 2'd1;
    localparam logic [1:0] PH_RESET = 2'd2;

    // config registers
    logic [lpe_pkg::TICK_W-1:0]  r_first_ticks;
    logic [lpe_pkg::TICK_W-1:0]  r_middle_ticks;
    logic [lpe_pkg::TICK_W-1:0]  r_tail_ticks;
    logic [lpe_pkg::LATCH_W-1:0] r_latch_ticks;

    logic [1:0]                  r_phase;
    logic [1:0]                  n_phase;
    logic                        r_final;

    // output register
    logic                        r_out_valid;
    logic                        r_out_level;
    logic [lpe_pkg::DUR_W-1:0]   r_out_first;
    logic [lpe_pkg::DUR_W-1:0]   r_out_second;
    logic                        r_out_eor;

    lpe_pkg::t_bit_status        bit_st;
    lpe_pkg::t_chunk_status      chunk_st;

    logic                        adv;
    logic                        sym_last;
    logic                        in_acc;
    logic                        bits_done;
    logic [lpe_pkg::DUR_W-1:0]   sum_high;
    logic [lpe_pkg::DUR_W-1:0]   sum_low;

    // config port always ready, writes belong between runs
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_ticks  <= '0;
            r_middle_ticks <= '0;
            r_tail_ticks   <= '0;
            r_latch_ticks  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpe_pkg::CFG_FIRST:  r_first_ticks  <= i_cfg_data[lpe_pkg::TICK_W-1:0];
                lpe_pkg::CFG_MIDDLE: r_middle_ticks <= i_cfg_data[lpe_pkg::TICK_W-1:0];
                lpe_pkg::CFG_TAIL:   r_tail_ticks   <= i_cfg_data[lpe_pkg::TICK_W-1:0];
                lpe_pkg::CFG_LATCH:  r_latch_ticks  <= i_cfg_data[lpe_pkg::LATCH_W-1:0];
            endcase
        end
    end

    // symbol moves into the output register when the slot is free or draining
    assign adv = (r_phase != PH_IDLE) && (!r_out_valid || !i_out_stall);

    // reset chunks follow only a final byte with nonzero latch time
    assign bits_done = (r_phase == PH_BITS) && bit_st.last;
    assign sym_last  = (bits_done && !(r_final && !chunk_st.empty)) ||
                       ((r_phase == PH_RESET) && chunk_st.last);

    // next byte may enter as the last symbol of this one leaves
    assign o_in_stall = (r_phase != PH_IDLE) && !(adv && sym_last);
    assign in_acc     = i_in_valid && !o_in_stall;

    lpe_bit_shift u_bit_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_byte   (i_pixel_byte),
        .i_shift  (adv && (r_phase == PH_BITS)),
        .o_status (bit_st)
    );

    lpe_chunk_gen #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_chunk_gen (
        .i_clk    (i_clk),
        .i_load   (in_acc),
        .i_latch  (r_latch_ticks),
        .i_step   (adv && (r_phase == PH_RESET)),
        .o_status (chunk_st)
    );

    always_comb begin
        priority if (in_acc) begin
            n_phase = PH_BITS;
        end else if (adv && sym_last) begin
            n_phase = PH_IDLE;
        end else if (adv && bits_done) begin
            n_phase = PH_RESET;
        end else begin
            n_phase = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_final <= i_final_byte;
        end
    end

    // both sums of two 15-bit registers fit in 16 bits
    assign sum_high = {1'b0, r_first_ticks} + {1'b0, r_middle_ticks};
    assign sum_low  = {1'b0, r_middle_ticks} + {1'b0, r_tail_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_eor <= sym_last;
            if (r_phase == PH_BITS) begin
                r_out_level <= 1'b1;
                if (bit_st.bit_val) begin
                    r_out_first  <= sum_high;
                    r_out_second <= {1'b0, r_tail_ticks};
                end else begin
                    r_out_first  <= {1'b0, r_first_ticks};
                    r_out_second <= sum_low;
                end
            end else begin
                // reset chunk: low line, second duration flags a full chunk
                r_out_level  <= 1'b0;
                r_out_first  <= chunk_st.piece;
                r_out_second <= {{(lpe_pkg::DUR_W-1){1'b0}}, chunk_st.full};
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_first_level     = r_out_level;
    assign o_first_duration  = r_out_first;
    assign o_second_level    = 1'b0;
    assign o_second_duration = r_out_second;
    assign o_end_of_run      = r_out_eor;

    // a non-final byte never enters the reset phase
    a_no_reset_without_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && bits_done && !r_final && !in_acc) |=> (r_phase == PH_IDLE))
        else $error("reset phase after a non-final byte");

    // reset chunks carry only a 0 or 1 second duration
    a_chunk_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_first_level) |-> (o_second_duration <= 16'd1))
        else $error("reset chunk with bad second duration");

    // no byte accepted while a run is in progress and its last symbol has not moved
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase != PH_IDLE) && !(adv && sym_last)) |-> o_in_stall)
        else $error("input accepted mid run");

    // a new symbol is only loaded after the previous one left or was taken
    a_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_out_first) && $stable(r_out_eor)))
        else $error("stalled output symbol overwritten");

endmodule

// ===== test/tb_led_pixel_pulse_encoder_core.sv =====
// self-checking testbench for the pixel byte to pulse symbol encoder
`timescale 1ns / 1ps

module tb_led_pixel_pulse_encoder_core;

    localparam int          CLK_PERIOD     = 8;
    localparam int          RESET_CYCLES   = 9;
    localparam int unsigned LINE_MAX_CHUNK = lpe_pkg::DEF_MAX_CHUNK;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int unsigned RUN_LIMIT      = 10_000_000;
    localparam int          NUM_DIR        = 21;
    localparam int          NUM_SETS       = 8;
    localparam int          RAND_PHASES    = 7;
    localparam int          PHASE_BYTES    = 38;

    // one pulse symbol as it leaves the block
    typedef struct packed {
        logic                      first_level;
        logic [lpe_pkg::DUR_W-1:0] first_duration;
        logic                      second_level;
        logic [lpe_pkg::DUR_W-1:0] second_duration;
        logic                      end_of_run;
    } t_pulse_sym;

    // one full register setting
    typedef struct packed {
        logic [lpe_pkg::TICK_W-1:0]  first_ticks;
        logic [lpe_pkg::TICK_W-1:0]  middle_ticks;
        logic [lpe_pkg::TICK_W-1:0]  tail_ticks;
        logic [lpe_pkg::LATCH_W-1:0] latch_ticks;
    } t_reg_set;

    // one stimulus row; setting >= 0 loads reg_tab[setting] before the byte
    // typed rows carry their symbol timings and latch chunk split spelled out
    typedef struct packed {
        int                         setting;
        logic [lpe_pkg::BYTE_W-1:0] pixel;
        logic                       last;
        logic                       typed;
        logic [lpe_pkg::DUR_W-1:0]  hi_one;
        logic [lpe_pkg::DUR_W-1:0]  lo_one;
        logic [lpe_pkg::DUR_W-1:0]  hi_zero;
        logic [lpe_pkg::DUR_W-1:0]  lo_zero;
        logic [6:0]                 full_chunks;
        logic [lpe_pkg::DUR_W-1:0]  tail_chunk;
    } t_dir_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [lpe_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [lpe_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_stall;
    logic [lpe_pkg::BYTE_W-1:0]     i_pixel_byte  = '0;
    logic                           i_final_byte  = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall   = 1'b0;
    logic                           o_first_level;
    logic [lpe_pkg::DUR_W-1:0]      o_first_duration;
    logic                           o_second_level;
    logic [lpe_pkg::DUR_W-1:0]      o_second_duration;
    logic                           o_end_of_run;

    // register mirror, all zero after reset
    logic [lpe_pkg::TICK_W-1:0]  first_q  = '0;
    logic [lpe_pkg::TICK_W-1:0]  middle_q = '0;
    logic [lpe_pkg::TICK_W-1:0]  tail_q   = '0;
    logic [lpe_pkg::LATCH_W-1:0] latch_q  = '0;

    // symbols still owed by the block, oldest first
    t_pulse_sym symbol_q [$];

    int          err_cnt    = 0;
    int          byte_cnt   = 0;
    int          frame_cnt  = 0;
    int          sym_cnt    = 0;
    int          chunk_cnt  = 0;
    int          set_cnt    = 0;
    int          gap_mode   = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned cycle_cnt  = 0;

    t_reg_set reg_tab [NUM_SETS] = '{
        '{15'd32767, 15'd32767, 15'd32767, 22'd3669960},  // full-scale timing, 56 full chunks
        '{15'd0,     15'd32767, 15'd0,     22'd65535},    // one full chunk, no terminator
        '{15'd1,     15'd2,     15'd3,     22'd1},        // lone one-tick terminator
        '{15'd21845, 15'd10922, 15'd4660,  22'd65536},    // full chunk plus one tick
        '{15'd32767, 15'd0,     15'd32767, 22'd4194303},  // latch beyond 56 chunks, rest dropped
        '{15'd10922, 15'd21845, 15'd32767, 22'd131070},   // two full chunks exactly
        '{15'd0,     15'd0,     15'd0,     22'd2796202},  // zero-width symbols, long latch
        '{15'd100,   15'd200,   15'd300,   22'd131071}    // two full chunks and a terminator
    };

    t_dir_row dir_tab [NUM_DIR] = '{
        // reset values: every duration zero and no latch chunks
        '{-1, 8'h00, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'hFF, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'hA5, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        // widest symbols, latch fills exactly 56 chunks
        '{0, 8'h80, 1'b1, 1'b1, 16'd65534, 16'd32767, 16'd32767, 16'd65534, 7'd56, 16'd0},
        '{-1, 8'h7F, 1'b0, 1'b1, 16'd65534, 16'd32767, 16'd32767, 16'd65534, 7'd0, 16'd0},
        '{-1, 8'hFF, 1'b1, 1'b1, 16'd65534, 16'd32767, 16'd32767, 16'd65534, 7'd56, 16'd0},
        // latch of exactly one chunk
        '{1, 8'h55, 1'b1, 1'b1, 16'd32767, 16'd0, 16'd0, 16'd32767, 7'd1, 16'd0},
        '{-1, 8'hAA, 1'b0, 1'b1, 16'd32767, 16'd0, 16'd0, 16'd32767, 7'd0, 16'd0},
        // single one-tick chunk
        '{2, 8'h3C, 1'b1, 1'b1, 16'd3, 16'd3, 16'd1, 16'd5, 7'd0, 16'd1},
        '{-1, 8'hC3, 1'b1, 1'b1, 16'd3, 16'd3, 16'd1, 16'd5, 7'd0, 16'd1},
        '{3, 8'h5A, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'h01, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'h96, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        // too long a latch: capped at 56 full chunks
        '{4, 8'h0F, 1'b1, 1'b1, 16'd32767, 16'd32767, 16'd32767, 16'd32767, 7'd56, 16'd0},
        '{-1, 8'hF0, 1'b1, 1'b1, 16'd32767, 16'd32767, 16'd32767, 16'd32767, 7'd56, 16'd0},
        '{5, 8'hE7, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'h18, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'h81, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{6, 8'h33, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{7, 8'hCC, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0},
        '{-1, 8'hFE, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 16'd0}
    };

    led_pixel_pulse_encoder_core #(
        .MAX_CHUNK (LINE_MAX_CHUNK)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_byte      (i_pixel_byte),
        .i_final_byte      (i_final_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_first_level     (o_first_level),
        .o_first_duration  (o_first_duration),
        .o_second_level    (o_second_level),
        .o_second_duration (o_second_duration),
        .o_end_of_run      (o_end_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output back-pressure: short random stalls with the odd long hold
    always @(posedge i_clk) begin : out_stall_gen
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (roll < 4) begin
            stall_left  <= $urandom_range(8, 40);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (roll < ((stall_mode == 1) ? 25 : 60));
        end
    end

    // compare every accepted output word with the oldest owed symbol
    always @(posedge i_clk) begin : sym_check
        t_pulse_sym want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (symbol_q.size() == 0) begin
                $error("symbol with nothing owed: level %0b dur %0d / %0d",
                       o_first_level, o_first_duration, o_second_duration);
                err_cnt++;
            end else begin
                want = symbol_q.pop_front();
                sym_cnt++;
                if (!want.first_level) chunk_cnt++;
                if (o_first_level !== want.first_level) begin
                    $error("first_level: expected %0b, got %0b", want.first_level, o_first_level);
                    err_cnt++;
                end
                if (o_first_duration !== want.first_duration) begin
                    $error("first_duration: expected %0d, got %0d",
                           want.first_duration, o_first_duration);
                    err_cnt++;
                end
                if (o_second_level !== want.second_level) begin
                    $error("second_level: expected %0b, got %0b",
                           want.second_level, o_second_level);
                    err_cnt++;
                end
                if (o_second_duration !== want.second_duration) begin
                    $error("second_duration: expected %0d, got %0d",
                           want.second_duration, o_second_duration);
                    err_cnt++;
                end
                if (o_end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b", want.end_of_run, o_end_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // queue the symbols of one byte, msb first, then the latch chunks
    // the last symbol held back so its end-of-run flag can be set
    function automatic void queue_run(logic [lpe_pkg::BYTE_W-1:0] pixel,
                                      logic [lpe_pkg::DUR_W-1:0] hi1,
                                      logic [lpe_pkg::DUR_W-1:0] lo1,
                                      logic [lpe_pkg::DUR_W-1:0] hi0,
                                      logic [lpe_pkg::DUR_W-1:0] lo0,
                                      int n_full, logic [lpe_pkg::DUR_W-1:0] rest);
        t_pulse_sym held;
        t_pulse_sym cur;
        held = '0;
        for (int b = lpe_pkg::BYTE_W - 1; b >= 0; b--) begin
            if (pixel[b]) begin
                cur = '{1'b1, hi1, 1'b0, lo1, 1'b0};
            end else begin
                cur = '{1'b1, hi0, 1'b0, lo0, 1'b0};
            end
            if (b != lpe_pkg::BYTE_W - 1) symbol_q.push_back(held);
            held = cur;
        end
        // full chunks carry a second duration of one
        for (int k = 0; k < n_full; k++) begin
            symbol_q.push_back(held);
            held = '{1'b0, lpe_pkg::DUR_W'(LINE_MAX_CHUNK), 1'b0, 16'd1, 1'b0};
        end
        // partial chunk doubles as terminator
        if (rest != 0) begin
            symbol_q.push_back(held);
            held = '{1'b0, rest, 1'b0, 16'd0, 1'b0};
        end
        held.end_of_run = 1'b1;
        symbol_q.push_back(held);
    endfunction

    // symbol timings and latch split from the current register mirror
    function automatic void predict_run(logic [lpe_pkg::BYTE_W-1:0] pixel, logic last);
        logic [lpe_pkg::DUR_W-1:0] hi1;
        logic [lpe_pkg::DUR_W-1:0] lo1;
        logic [lpe_pkg::DUR_W-1:0] hi0;
        logic [lpe_pkg::DUR_W-1:0] lo0;
        logic [lpe_pkg::DUR_W-1:0] rest;
        int                        n_full;
        hi1    = lpe_pkg::DUR_W'(first_q) + lpe_pkg::DUR_W'(middle_q);
        lo1    = lpe_pkg::DUR_W'(tail_q);
        hi0    = lpe_pkg::DUR_W'(first_q);
        lo0    = lpe_pkg::DUR_W'(middle_q) + lpe_pkg::DUR_W'(tail_q);
        n_full = 0;
        rest   = '0;
        if (last) begin
            n_full = int'(latch_q / LINE_MAX_CHUNK);
            rest   = lpe_pkg::DUR_W'(latch_q % LINE_MAX_CHUNK);
            // anything past the chunk budget is dropped
            if (n_full >= lpe_pkg::MAX_RESET_CHUNKS) begin
                n_full = lpe_pkg::MAX_RESET_CHUNKS;
                rest   = '0;
            end
        end
        queue_run(pixel, hi1, lo1, hi0, lo0, n_full, rest);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_mode == 0 || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [lpe_pkg::TICK_W-1:0] pick_ticks();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 60) return lpe_pkg::TICK_W'($urandom_range(0, 1000));
        return lpe_pkg::TICK_W'($urandom_range(0, 32767));
    endfunction

    function automatic t_reg_set random_regs();
        t_reg_set rs;
        int       roll;
        rs.first_ticks  = pick_ticks();
        rs.middle_ticks = pick_ticks();
        rs.tail_ticks   = pick_ticks();
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            rs.latch_ticks = '0;
        end else if (roll < 30) begin
            rs.latch_ticks = lpe_pkg::LATCH_W'(LINE_MAX_CHUNK * $urandom_range(1, 4));
        end else if (roll < 65) begin
            rs.latch_ticks = lpe_pkg::LATCH_W'($urandom_range(1, 200000));
        end else if (roll < 90) begin
            rs.latch_ticks = lpe_pkg::LATCH_W'($urandom_range(0, 3669960));
        end else begin
            rs.latch_ticks = lpe_pkg::LATCH_W'($urandom_range(3669961, 4194303));
        end
        return rs;
    endfunction

    // write all four registers back to back, mirror follows
    task automatic load_regs(t_reg_set rs);
        logic [lpe_pkg::CFG_IDX_W-1:0]  idx;
        logic [lpe_pkg::CFG_DATA_W-1:0] val;
        for (int r = 0; r < 4; r++) begin
            idx = lpe_pkg::CFG_IDX_W'(r);
            unique case (idx)
                lpe_pkg::CFG_FIRST: begin
                    val     = lpe_pkg::CFG_DATA_W'(rs.first_ticks);
                    first_q = rs.first_ticks;
                end
                lpe_pkg::CFG_MIDDLE: begin
                    val      = lpe_pkg::CFG_DATA_W'(rs.middle_ticks);
                    middle_q = rs.middle_ticks;
                end
                lpe_pkg::CFG_TAIL: begin
                    val    = lpe_pkg::CFG_DATA_W'(rs.tail_ticks);
                    tail_q = rs.tail_ticks;
                end
                default: begin
                    val     = lpe_pkg::CFG_DATA_W'(rs.latch_ticks);
                    latch_q = rs.latch_ticks;
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        set_cnt++;
    endtask

    // wait until every owed symbol is out, then let the pipe settle
    task automatic drain_symbols();
        while (symbol_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one pixel word, expectations queued once it is taken
    task automatic send_byte(t_dir_row row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_byte <= row.pixel;
        i_final_byte <= row.last;
        do @(posedge i_clk); while (o_in_stall);
        if (row.typed) begin
            queue_run(row.pixel, row.hi_one, row.lo_one, row.hi_zero, row.lo_zero,
                      int'(row.full_chunks), row.tail_chunk);
        end else begin
            predict_run(row.pixel, row.last);
        end
        byte_cnt++;
        if (row.last) frame_cnt++;
    endtask

    initial begin
        t_dir_row row;
        int       sent;
        int       flen;
        int       roll;
        int       max_len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, register reloads only with the pipe empty
        gap_mode   = 1;
        stall_mode = 1;
        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_tab[i].setting >= 0) begin
                i_in_valid <= 1'b0;
                drain_symbols();
                load_regs(reg_tab[dir_tab[i].setting]);
            end
            send_byte(dir_tab[i]);
        end

        // random frames, one register setting per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            drain_symbols();
            load_regs(random_regs());
            gap_mode   = (ph % 3 == 0) ? 0 : 1;
            stall_mode = ph % 3;
            max_len    = (ph % 2 == 0) ? 12 : 3;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                flen = $urandom_range(1, max_len);
                // a few frames are cut short and never see their final byte
                roll = $urandom_range(0, 99);
                for (int k = 0; k < flen; k++) begin
                    row       = '0;
                    row.setting = -1;
                    row.pixel = lpe_pkg::BYTE_W'($urandom_range(0, 255));
                    if (roll < 5) row.pixel = '0;
                    else if (roll < 10) row.pixel = '1;
                    row.last  = (k == flen - 1) && (roll >= 15);
                    send_byte(row);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        drain_symbols();
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel bytes in %0d latched frames, %0d symbols checked, %0d chunks",
                 byte_cnt, frame_cnt, sym_cnt, chunk_cnt);
        $display("%0d register settings, zero and full-scale timings and latch lengths included",
                 set_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpe_pkg.sv
rtl/lpe_bit_shift.sv
rtl/lpe_chunk_gen.sv
rtl/led_pixel_pulse_encoder_core.sv
test/tb_led_pixel_pulse_encoder_core.sv
